@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the project checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while DIS is high
`define ASSERT_IMPLY(LABEL, CLK, DIS, A, B) \
    LABEL: assert property (@(posedge CLK) disable iff (DIS) (A) |-> (B)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while DIS is high
`define ASSERT_NEXT(LABEL, CLK, DIS, A, B) \
    LABEL: assert property (@(posedge CLK) disable iff (DIS) (A) |=> (B)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/ipf_pkg.sv @@
// ----------------------------------------------------------------------------
// ipf_pkg
// Types, widths and register codes of the im2col patch fetcher.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int NUM_PLANES_DEF = 4;
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;

    localparam int PIX_W   = 32;
    localparam int POS_W   = 6;
    localparam int PLANE_W = 2;
    localparam int DIM_W   = 7;
    localparam int PAD_W   = 6;
    localparam int PROD_W  = POS_W + DIM_W;
    localparam int COORD_W = PROD_W + 3;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_PAD_ROWS     = 3'd2;
    localparam logic [2:0] REG_PAD_COLS     = 3'd3;
    localparam logic [2:0] REG_STEP_ROWS    = 3'd4;
    localparam logic [2:0] REG_STEP_COLS    = 3'd5;
    localparam logic [2:0] REG_DILATE_ROWS  = 3'd6;
    localparam logic [2:0] REG_DILATE_COLS  = 3'd7;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef struct packed {
        logic               func;
        logic [PLANE_W-1:0] plane;
        logic [POS_W-1:0]   load_row;
        logic [POS_W-1:0]   load_col;
        logic [PIX_W-1:0]   pixel_bits;
        logic [POS_W-1:0]   tap_row;
        logic [POS_W-1:0]   tap_col;
        logic [POS_W-1:0]   out_y;
        logic [POS_W-1:0]   out_x;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] entry_bits;
        logic             is_padding;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] image_width;
        logic [PAD_W-1:0] pad_rows;
        logic [PAD_W-1:0] pad_cols;
        logic [DIM_W-1:0] step_rows;
        logic [DIM_W-1:0] step_cols;
        logic [DIM_W-1:0] dilate_rows;
        logic [DIM_W-1:0] dilate_cols;
    } t_cfg;

    typedef struct packed {
        logic rd;
        logic wr;
        logic pad;
    } t_mem_ctl;

endpackage

@@ design/im2col_patch_fetch_core.sv @@
// ----------------------------------------------------------------------------
// im2col_patch_fetch_core
// im2col patch fetcher with padding, stride and dilation over an on-chip
// multi-plane image store.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_item): a load transaction
// writes one pixel into the image store and returns nothing; a fetch
// transaction returns one column-matrix entry on the output channel
// (o_out_valid / i_out_ready / o_out_item), in order of acceptance.
// Throughput: one transaction per cycle while o_in_ready stays high, set by
// the single store port that serves one load or one fetch each cycle.
// A fetch result passes through the product stage, then the store read, then
// the output register before it is valid.
// Padded positions read no memory and come back as zero with is_padding set.
// Stall: while the output register holds a result, two more fetches can
// enter and wait in the product and read stages; loads keep flowing past a
// stalled fetch. o_in_ready drops only when the whole pipe is full.
// Reset clears pipeline valids and sets the registers to their defaults
// (64x64 image, no padding, unit stride and dilation). The image store is
// not cleared; pixels must be loaded before they are fetched.
// Configuration: APB-style, registers at byte address 4*index, pready high.
// ----------------------------------------------------------------------------
module im2col_patch_fetch_core #(
    parameter int NUM_PLANES = ipf_pkg::NUM_PLANES_DEF,
    parameter int MAX_ROWS   = ipf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = ipf_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ipf_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ipf_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipf_pkg::APB_AW-1:0]  paddr,
    input  logic [ipf_pkg::APB_DW-1:0]  pwdata,
    output logic [ipf_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int DEPTH  = NUM_PLANES * MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ipf_pkg::t_cfg       r_cfg;
    logic [2:0]          reg_idx;

    logic                       a_valid;
    logic                       a_fetch;
    logic                       a_adv;
    ipf_pkg::t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0]          mem_addr;
    logic [ipf_pkg::PIX_W-1:0]  mem_wdata;
    logic [ipf_pkg::PIX_W-1:0]  mem_rdata;

    logic               r_b_valid;
    logic               r_b_pad;
    logic               r_o_valid;
    ipf_pkg::t_out_item r_o_item;
    logic               o_free;
    logic               b_free;
    logic               b_adv;
    logic               in_acc;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height <= ipf_pkg::DIM_W'(64);
            r_cfg.image_width  <= ipf_pkg::DIM_W'(64);
            r_cfg.pad_rows     <= '0;
            r_cfg.pad_cols     <= '0;
            r_cfg.step_rows    <= ipf_pkg::DIM_W'(1);
            r_cfg.step_cols    <= ipf_pkg::DIM_W'(1);
            r_cfg.dilate_rows  <= ipf_pkg::DIM_W'(1);
            r_cfg.dilate_cols  <= ipf_pkg::DIM_W'(1);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                ipf_pkg::REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[ipf_pkg::DIM_W-1:0];
                ipf_pkg::REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[ipf_pkg::DIM_W-1:0];
                ipf_pkg::REG_PAD_ROWS:     r_cfg.pad_rows     <= pwdata[ipf_pkg::PAD_W-1:0];
                ipf_pkg::REG_PAD_COLS:     r_cfg.pad_cols     <= pwdata[ipf_pkg::PAD_W-1:0];
                ipf_pkg::REG_STEP_ROWS:    r_cfg.step_rows    <= pwdata[ipf_pkg::DIM_W-1:0];
                ipf_pkg::REG_STEP_COLS:    r_cfg.step_cols    <= pwdata[ipf_pkg::DIM_W-1:0];
                ipf_pkg::REG_DILATE_ROWS:  r_cfg.dilate_rows  <= pwdata[ipf_pkg::DIM_W-1:0];
                ipf_pkg::REG_DILATE_COLS:  r_cfg.dilate_cols  <= pwdata[ipf_pkg::DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ipf_pkg::REG_IMAGE_HEIGHT: prdata = ipf_pkg::APB_DW'(r_cfg.image_height);
            ipf_pkg::REG_IMAGE_WIDTH:  prdata = ipf_pkg::APB_DW'(r_cfg.image_width);
            ipf_pkg::REG_PAD_ROWS:     prdata = ipf_pkg::APB_DW'(r_cfg.pad_rows);
            ipf_pkg::REG_PAD_COLS:     prdata = ipf_pkg::APB_DW'(r_cfg.pad_cols);
            ipf_pkg::REG_STEP_ROWS:    prdata = ipf_pkg::APB_DW'(r_cfg.step_rows);
            ipf_pkg::REG_STEP_COLS:    prdata = ipf_pkg::APB_DW'(r_cfg.step_cols);
            ipf_pkg::REG_DILATE_ROWS:  prdata = ipf_pkg::APB_DW'(r_cfg.dilate_rows);
            ipf_pkg::REG_DILATE_COLS:  prdata = ipf_pkg::APB_DW'(r_cfg.dilate_cols);
        endcase
    end

    // pipe control: loads leave stage A unconditionally, fetches need stage B
    assign o_free     = !r_o_valid || i_out_ready;
    assign b_adv      = r_b_valid && o_free;
    assign b_free     = !r_b_valid || o_free;
    assign a_adv      = a_valid && (!a_fetch || b_free);
    assign o_in_ready = !a_valid || a_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    ipf_addr_gen #(
        .NUM_PLANES (NUM_PLANES),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .ADDR_W     (ADDR_W)
    ) u_addr_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_acc),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .i_adv   (a_adv),
        .o_valid (a_valid),
        .o_fetch (a_fetch),
        .o_ctl   (mem_ctl),
        .o_addr  (mem_addr),
        .o_wdata (mem_wdata)
    );

    ipf_image_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_image_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv && a_fetch) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && a_fetch) begin
            r_b_pad <= mem_ctl.pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_adv) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_o_item.entry_bits <= r_b_pad ? '0 : mem_rdata;
            r_o_item.is_padding <= r_b_pad;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_o_item;

endmodule

@@ design/ipf_addr_gen.sv @@
// ----------------------------------------------------------------------------
// ipf_addr_gen
// Stage A: tap and position products, source coordinate, bounds check and
// image store address for loads and fetches.
// ----------------------------------------------------------------------------
module ipf_addr_gen #(
    parameter int NUM_PLANES = ipf_pkg::NUM_PLANES_DEF,
    parameter int MAX_ROWS   = ipf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = ipf_pkg::MAX_COLS_DEF,
    parameter int ADDR_W     = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  ipf_pkg::t_in_item          i_item,
    input  ipf_pkg::t_cfg              i_cfg,
    input  logic                       i_adv,
    output logic                       o_valid,
    output logic                       o_fetch,
    output ipf_pkg::t_mem_ctl          o_ctl,
    output logic [ADDR_W-1:0]          o_addr,
    output logic [ipf_pkg::PIX_W-1:0]  o_wdata
);

    localparam int PLANE_SIZE = MAX_ROWS * MAX_COLS;

    logic                         r_valid;
    logic                         r_func;
    logic [ipf_pkg::PLANE_W-1:0]  r_plane;
    logic [ipf_pkg::POS_W-1:0]    r_lrow;
    logic [ipf_pkg::POS_W-1:0]    r_lcol;
    logic [ipf_pkg::PIX_W-1:0]    r_pix;
    logic [ipf_pkg::PROD_W-1:0]   r_py;
    logic [ipf_pkg::PROD_W-1:0]   r_ty;
    logic [ipf_pkg::PROD_W-1:0]   r_px;
    logic [ipf_pkg::PROD_W-1:0]   r_tx;

    logic signed [ipf_pkg::COORD_W-1:0] sr;
    logic signed [ipf_pkg::COORD_W-1:0] sc;
    int   h_eff;
    int   w_eff;
    int   row_i;
    int   col_i;
    logic plane_ok;
    logic in_image;
    logic load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func  <= i_item.func;
            r_plane <= i_item.plane;
            r_lrow  <= i_item.load_row;
            r_lcol  <= i_item.load_col;
            r_pix   <= i_item.pixel_bits;
            r_py    <= ipf_pkg::PROD_W'(i_item.out_y) * ipf_pkg::PROD_W'(i_cfg.step_rows);
            r_ty    <= ipf_pkg::PROD_W'(i_item.tap_row) * ipf_pkg::PROD_W'(i_cfg.dilate_rows);
            r_px    <= ipf_pkg::PROD_W'(i_item.out_x) * ipf_pkg::PROD_W'(i_cfg.step_cols);
            r_tx    <= ipf_pkg::PROD_W'(i_item.tap_col) * ipf_pkg::PROD_W'(i_cfg.dilate_cols);
        end
    end

    always_comb begin
        sr = ipf_pkg::COORD_W'(r_py) + ipf_pkg::COORD_W'(r_ty)
           - ipf_pkg::COORD_W'(i_cfg.pad_rows);
        sc = ipf_pkg::COORD_W'(r_px) + ipf_pkg::COORD_W'(r_tx)
           - ipf_pkg::COORD_W'(i_cfg.pad_cols);
        h_eff = (int'(i_cfg.image_height) < MAX_ROWS) ? int'(i_cfg.image_height) : MAX_ROWS;
        w_eff = (int'(i_cfg.image_width) < MAX_COLS) ? int'(i_cfg.image_width) : MAX_COLS;
        plane_ok = int'(r_plane) < NUM_PLANES;
        in_image = plane_ok
              && !sr[ipf_pkg::COORD_W-1] && (int'(sr) < h_eff)
              && !sc[ipf_pkg::COORD_W-1] && (int'(sc) < w_eff);
        load_ok = plane_ok && (int'(r_lrow) < MAX_ROWS) && (int'(r_lcol) < MAX_COLS);
        if (r_func == ipf_pkg::FUNC_FETCH) begin
            row_i = int'(sr);
            col_i = int'(sc);
        end else begin
            row_i = int'(r_lrow);
            col_i = int'(r_lcol);
        end
    end

    assign o_valid   = r_valid;
    assign o_fetch   = (r_func == ipf_pkg::FUNC_FETCH);
    assign o_ctl.wr  = i_adv && (r_func == ipf_pkg::FUNC_LOAD) && load_ok;
    assign o_ctl.rd  = i_adv && (r_func == ipf_pkg::FUNC_FETCH) && in_image;
    assign o_ctl.pad = !in_image;
    assign o_addr    = ADDR_W'(int'(r_plane) * PLANE_SIZE + row_i * MAX_COLS + col_i);
    assign o_wdata   = r_pix;

endmodule

@@ design/ipf_image_mem.sv @@
// ----------------------------------------------------------------------------
// ipf_image_mem
// Single-port image store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ipf_image_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                       i_clk,
    input  ipf_pkg::t_mem_ctl          i_ctl,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic [ipf_pkg::PIX_W-1:0]  i_wdata,
    output logic [ipf_pkg::PIX_W-1:0]  o_rdata
);

    logic [ipf_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [ipf_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ipf_checker.sv @@
// ----------------------------------------------------------------------------
// ipf_checker
// Port-level checks of the im2col patch fetcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipf_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ipf_pkg::t_out_item o_out_item,
    input logic               pready
);

    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, !i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item))
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid && o_in_ready)
    `ASSERT_IMPLY(a_pready_high, i_clk, !i_rst_n, 1'b1, pready)

endmodule

bind im2col_patch_fetch_core ipf_checker u_ipf_checker (.*);
